[sv/mbr_pkg.sv]
// Package for the mono bitmap resize block: shared constants, codes and types.
// Used by mbr_engine, mono_bitmap_resize_core, mbr_checker and tb_top; depends on nothing.
package mbr_pkg;

   localparam int STORE_WORDS_DEF = 256;
   // Wide enough for row * words + word over the largest register values
   localparam int ADDR_W = 15;
   localparam int ROW_WORDS = 32;
   localparam int ERR_W = 12;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_RUN  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [1:0] MODE_KEEP  = 2'd0;
   localparam logic [1:0] MODE_SCALE = 2'd1;

   localparam logic [2:0] CSR_MODE       = 3'd0;
   localparam logic [2:0] CSR_SRC_WIDTH  = 3'd1;
   localparam logic [2:0] CSR_SRC_HEIGHT = 3'd2;
   localparam logic [2:0] CSR_DST_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_DST_HEIGHT = 3'd4;

   typedef struct packed {
      logic [1:0] mode;
      logic [4:0] src_words;
      logic [8:0] src_height;
      logic [4:0] dst_words;
      logic [8:0] dst_height;
   } cfg_type;

   typedef struct packed {
      logic              src_rd;
      logic [ADDR_W-1:0] src_addr;
      logic              dst_rd;
      logic [ADDR_W-1:0] dst_raddr;
      logic              dst_wr;
      logic [ADDR_W-1:0] dst_waddr;
      logic [15:0]       dst_wdata;
   } mem_req_type;

endpackage

[sv/mbr_engine.sv]
// Run sequencer: clears the destination store; keep mode then crops/pads and
// scale mode (read-modify-write) scales the source in. Depends on mbr_pkg.
module mbr_engine import mbr_pkg::*; #(
   parameter int STORE_WORDS = STORE_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  cfg_type     cfg,
   input  logic [15:0] src_q,
   input  logic [15:0] dst_q,
   output mem_req_type mem_req,
   output logic        done,
   output logic        idle
);

   localparam int AW = $clog2(STORE_WORDS);

   typedef enum logic [3:0] {
      S_IDLE, S_CLR, S_KEEP, S_KFLUSH, S_ROW, S_FETCH, S_FWAIT,
      S_PIX, S_REP, S_VSTEP, S_COPY, S_CFLUSH, S_DONE
   } state_type;

   state_type state_ff;
   logic [AW-1:0]           cnt_ff;
   logic [8:0]              k_ff, rows_ff, i_ff, j_ff, d_ff;
   logic [4:0]              w_ff, cols_ff;
   logic [ADDR_W-1:0]       sbase_ff, qbase_ff, nbase_ff;
   logic signed [ERR_W-1:0] e_ff, f_ff;
   logic                    srcok_ff;
   logic [15:0]             srcword_ff;
   logic [15:0]             rowbuf_ff [ROW_WORDS];
   logic                    done_ff;
   logic                    init_ff;

   logic                    p_valid_ff, p_keep_ff, p_ok_ff, p_srcok_ff;
   logic [ADDR_W-1:0]       p_waddr_ff;
   logic [4:0]              p_w_ff;

   logic [8:0]              srcw;
   logic signed [ERR_W-1:0] two_dw, two_sw, two_dh, two_sh, en, en2, er;
   logic [ADDR_W-1:0]       keep_saddr, keep_daddr, fetch_addr, copy_addr;
   logic                    bit_cur, last_pix;
   logic [8:0]              next_i;
   state_type               adv_state;

   always_comb begin
      srcw   = {cfg.src_words, 4'b0};
      two_dw = $signed({2'b0, cfg.dst_words, 5'b0});
      two_sw = $signed({2'b0, cfg.src_words, 5'b0});
      two_dh = $signed({2'b0, cfg.dst_height, 1'b0});
      two_sh = $signed({2'b0, cfg.src_height, 1'b0});
      en  = e_ff + two_dw;
      en2 = en - two_sw;
      er  = e_ff - two_sw;
      keep_saddr = sbase_ff + ADDR_W'(w_ff);
      keep_daddr = qbase_ff + ADDR_W'(w_ff);
      fetch_addr = sbase_ff + ADDR_W'(i_ff[8:4]);
      copy_addr  = qbase_ff + ADDR_W'(w_ff);
      bit_cur  = srcword_ff[~i_ff[3:0]];
      last_pix = (i_ff == srcw - 9'd1);
      next_i   = i_ff + 9'd1;
      if (last_pix) begin
         adv_state = S_VSTEP;
      end else if (next_i[3:0] == 4'd0) begin
         adv_state = S_FETCH;
      end else begin
         adv_state = S_PIX;
      end
   end

   always_comb begin
      mem_req.src_rd    = (state_ff == S_FETCH) || (state_ff == S_KEEP);
      mem_req.src_addr  = (state_ff == S_KEEP) ? keep_saddr : fetch_addr;
      mem_req.dst_rd    = (state_ff == S_COPY);
      mem_req.dst_raddr = copy_addr;
      if (state_ff == S_CLR) begin
         mem_req.dst_wr    = 1'b1;
         mem_req.dst_waddr = ADDR_W'(cnt_ff);
         mem_req.dst_wdata = 16'h0;
      end else begin
         mem_req.dst_wr    = p_valid_ff && p_ok_ff;
         mem_req.dst_waddr = p_waddr_ff;
         if (p_keep_ff) begin
            mem_req.dst_wdata = p_srcok_ff ? src_q : 16'h0;
         end else begin
            mem_req.dst_wdata = rowbuf_ff[p_w_ff] | dst_q;
         end
      end
   end

   assign done = done_ff;
   assign idle = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         // clearing pass over the destination store right after reset
         state_ff   <= S_CLR;
         cnt_ff     <= '0;
         init_ff    <= 1'b1;
         p_valid_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         done_ff    <= 1'b0;
         p_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  cnt_ff   <= '0;
                  state_ff <= S_CLR;
               end
            end
            S_CLR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == AW'(STORE_WORDS - 1)) begin
                  sbase_ff <= '0;
                  qbase_ff <= '0;
                  nbase_ff <= '0;
                  w_ff     <= '0;
                  k_ff     <= '0;
                  f_ff     <= '0;
                  rows_ff  <= (cfg.src_height < cfg.dst_height) ?
                              cfg.src_height : cfg.dst_height;
                  cols_ff  <= (cfg.src_words < cfg.dst_words) ?
                              cfg.src_words : cfg.dst_words;
                  if (init_ff) begin
                     init_ff  <= 1'b0;
                     state_ff <= S_IDLE;
                  end else begin
                     case (cfg.mode)
                        MODE_KEEP: begin
                           if (cfg.src_height == 9'd0 || cfg.dst_height == 9'd0 ||
                               cfg.src_words == 5'd0 || cfg.dst_words == 5'd0) begin
                              state_ff <= S_DONE;
                           end else begin
                              state_ff <= S_KEEP;
                           end
                        end
                        MODE_SCALE: state_ff <= S_ROW;
                        default:    state_ff <= S_DONE;
                     endcase
                  end
               end
            end
            S_KEEP: begin
               // k_ff counts rows here
               p_valid_ff <= 1'b1;
               p_keep_ff  <= 1'b1;
               p_waddr_ff <= keep_daddr;
               p_ok_ff    <= keep_daddr < ADDR_W'(STORE_WORDS);
               p_srcok_ff <= keep_saddr < ADDR_W'(STORE_WORDS);
               if (w_ff == cols_ff - 5'd1) begin
                  w_ff     <= '0;
                  k_ff     <= k_ff + 9'd1;
                  sbase_ff <= sbase_ff + ADDR_W'(cfg.src_words);
                  qbase_ff <= qbase_ff + ADDR_W'(cfg.dst_words);
                  if (k_ff == rows_ff - 9'd1) begin
                     state_ff <= S_KFLUSH;
                  end
               end else begin
                  w_ff <= w_ff + 5'd1;
               end
            end
            S_KFLUSH: state_ff <= S_DONE;
            S_ROW: begin
               if (k_ff == cfg.src_height) begin
                  state_ff <= S_DONE;
               end else begin
                  f_ff <= f_ff + two_dh;
                  for (int n = 0; n < ROW_WORDS; n++) begin
                     rowbuf_ff[n] <= 16'h0;
                  end
                  e_ff <= '0;
                  i_ff <= '0;
                  j_ff <= '0;
                  d_ff <= '0;
                  state_ff <= (cfg.src_words == 5'd0) ? S_VSTEP : S_FETCH;
               end
            end
            S_FETCH: begin
               srcok_ff <= fetch_addr < ADDR_W'(STORE_WORDS);
               state_ff <= S_FWAIT;
            end
            S_FWAIT: begin
               srcword_ff <= srcok_ff ? src_q : 16'h0;
               state_ff   <= S_PIX;
            end
            S_PIX: begin
               if (en <= 12'sd0) begin
                  // skipped source pixel merges into the previous output pixel
                  if (bit_cur) begin
                     rowbuf_ff[d_ff[8:4]][~d_ff[3:0]] <= 1'b1;
                  end
                  e_ff     <= en;
                  i_ff     <= next_i;
                  state_ff <= adv_state;
               end else begin
                  if (bit_cur) begin
                     rowbuf_ff[j_ff[8:4]][~j_ff[3:0]] <= 1'b1;
                  end
                  d_ff <= j_ff;
                  j_ff <= j_ff + 9'd1;
                  e_ff <= en2;
                  if (en2 <= 12'sd0) begin
                     i_ff     <= next_i;
                     state_ff <= adv_state;
                  end else begin
                     state_ff <= S_REP;
                  end
               end
            end
            S_REP: begin
               if (bit_cur) begin
                  rowbuf_ff[j_ff[8:4]][~j_ff[3:0]] <= 1'b1;
               end
               d_ff <= j_ff;
               j_ff <= j_ff + 9'd1;
               e_ff <= er;
               if (er <= 12'sd0) begin
                  i_ff     <= next_i;
                  state_ff <= adv_state;
               end
            end
            S_VSTEP: begin
               if (f_ff > 12'sd0) begin
                  qbase_ff <= nbase_ff;
                  nbase_ff <= nbase_ff + ADDR_W'(cfg.dst_words);
                  f_ff     <= f_ff - two_sh;
               end
               w_ff     <= '0;
               state_ff <= (cfg.dst_words == 5'd0) ? S_CFLUSH : S_COPY;
            end
            S_COPY: begin
               p_valid_ff <= 1'b1;
               p_keep_ff  <= 1'b0;
               p_waddr_ff <= copy_addr;
               p_ok_ff    <= copy_addr < ADDR_W'(STORE_WORDS);
               p_w_ff     <= w_ff;
               w_ff       <= w_ff + 5'd1;
               if (w_ff == cfg.dst_words - 5'd1) begin
                  state_ff <= S_CFLUSH;
               end
            end
            S_CFLUSH: begin
               // last merged word is written this cycle
               if (f_ff > 12'sd0) begin
                  state_ff <= S_VSTEP;
               end else begin
                  k_ff     <= k_ff + 9'd1;
                  sbase_ff <= sbase_ff + ADDR_W'(cfg.src_words);
                  state_ff <= S_ROW;
               end
            end
            S_DONE: begin
               done_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[sv/mono_bitmap_resize_core.sv]
// Top level of the mono bitmap resize block: CSRs, transfer handshake and both
// word stores. Depends on mbr_pkg and mbr_engine.
//
// After reset the destination store is cleared while the input is stalled.
// A load transfer writes one source word and its response follows in the next
// cycle; a read transfer is answered through the registered store port and the
// read-wait state. A run transfer clears the destination store first, one word
// a cycle; keep mode then copies one word a cycle and flushes the last write;
// scale mode fetches the words of each source row, steps through its pixels
// into a row buffer, and merges the buffer into each destination row the row
// maps to by read-modify-write. The done state then hands the run response
// out. Only one transfer is in work at a time; the next is taken once its
// response register is free.
module mono_bitmap_resize_core import mbr_pkg::*; #(
   parameter int STORE_WORDS = STORE_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_word_index,
   input  logic [15:0] req_word_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_result_word,
   output logic        rsp_run_done,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_write_data
);

   localparam int AW = $clog2(STORE_WORDS);

   typedef enum logic [1:0] {T_IDLE, T_RDWAIT, T_RUN} top_state_type;

   top_state_type state_ff;
   cfg_type       cfg_ff;
   logic          rsp_valid_ff, rsp_run_done_ff, rd_ok_ff;
   logic [15:0]   rsp_word_ff;
   logic [15:0]   src_mem [STORE_WORDS];
   logic [15:0]   dst_mem [STORE_WORDS];
   logic [15:0]   src_q_ff, dst_q_ff;

   logic              accept, idx_ok, run_start, eng_done, eng_idle, dst_rd, rsp_set;
   logic [ADDR_W-1:0] idx_ext, dst_raddr;
   mem_req_type       mem_req;

   assign req_stall = !((state_ff == T_IDLE) && eng_idle && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;
   assign idx_ext   = ADDR_W'(req_word_index);
   assign idx_ok    = idx_ext < ADDR_W'(STORE_WORDS);
   assign run_start = accept && (req_operation == OP_RUN);

   assign rsp_set = ((state_ff == T_IDLE) && accept &&
                     !(req_operation inside {OP_RUN, OP_READ})) ||
                    (state_ff == T_RDWAIT) ||
                    ((state_ff == T_RUN) && eng_done);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_word = rsp_word_ff;
   assign rsp_run_done    = rsp_run_done_ff;

   assign dst_rd    = mem_req.dst_rd || (accept && req_operation == OP_READ);
   assign dst_raddr = (state_ff == T_RUN) ? mem_req.dst_raddr : idx_ext;

   mbr_engine #(
      .STORE_WORDS(STORE_WORDS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .start   (run_start),
      .cfg     (cfg_ff),
      .src_q   (src_q_ff),
      .dst_q   (dst_q_ff),
      .mem_req (mem_req),
      .done    (eng_done),
      .idle    (eng_idle)
   );

   always_ff @(posedge clock) begin
      if (accept && req_operation == OP_LOAD && idx_ok) begin
         src_mem[idx_ext[AW-1:0]] <= req_word_data;
      end
      if (mem_req.src_rd) begin
         src_q_ff <= src_mem[mem_req.src_addr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.dst_wr) begin
         dst_mem[mem_req.dst_waddr[AW-1:0]] <= mem_req.dst_wdata;
      end
      if (dst_rd) begin
         dst_q_ff <= dst_mem[dst_raddr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode       <= MODE_SCALE;
         cfg_ff.src_words  <= 5'd2;
         cfg_ff.src_height <= 9'd32;
         cfg_ff.dst_words  <= 5'd2;
         cfg_ff.dst_height <= 9'd32;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MODE:       cfg_ff.mode       <= csr_write_data[1:0];
            CSR_SRC_WIDTH:  cfg_ff.src_words  <= csr_write_data[8:4];
            CSR_SRC_HEIGHT: cfg_ff.src_height <= csr_write_data;
            CSR_DST_WIDTH:  cfg_ff.dst_words  <= csr_write_data[8:4];
            CSR_DST_HEIGHT: cfg_ff.dst_height <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_set) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            T_IDLE: begin
               if (accept) begin
                  rsp_word_ff     <= 16'h0;
                  rsp_run_done_ff <= 1'b0;
                  rd_ok_ff        <= idx_ok;
                  case (req_operation)
                     OP_RUN:  state_ff <= T_RUN;
                     OP_READ: state_ff <= T_RDWAIT;
                     default: ;
                  endcase
               end
            end
            T_RDWAIT: begin
               rsp_word_ff <= rd_ok_ff ? dst_q_ff : 16'h0;
               state_ff    <= T_IDLE;
            end
            T_RUN: begin
               if (eng_done) begin
                  rsp_run_done_ff <= 1'b1;
                  state_ff        <= T_IDLE;
               end
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end

endmodule

[test/mbr_checker.sv]
// Checker for mono_bitmap_resize_core: watches the CSR port and both channels,
// predicts each response from its own copy of the stores and registers.
// Depends on mbr_pkg.
module mbr_checker import mbr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_word_index,
   input  logic [15:0] req_word_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_result_word,
   input  logic        rsp_run_done,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_write_data,
   output int          failures
);

   typedef struct {
      logic [15:0] word;
      logic        done;
   } rsp_type;

   logic [15:0] src_img [256];
   logic [15:0] dst_img [256];
   logic [15:0] line_buf [ROW_WORDS];
   logic [1:0]  mode;
   logic [8:0]  src_w, src_h, dst_w, dst_h;
   rsp_type     pending_rsp [$];
   int          mismatches;

   function automatic logic src_bit(int row, int col, int sw);
      int a;
      a = row * sw + (col >> 4);
      if (a >= 256) return 1'b0;
      return src_img[a][15 - (col & 15)];
   endfunction

   function automatic void or_dst(int row, int w, int dw, logic [15:0] v);
      int a;
      a = row * dw + w;
      if (a < 256) dst_img[a] = dst_img[a] | v;
   endfunction

   function automatic void set_line_bit(int d);
      line_buf[(d >> 4) & (ROW_WORDS - 1)][15 - (d & 15)] = 1'b1;
   endfunction

   // Horizontal Bresenham pass of one source row into line_buf
   function automatic void scale_row(int row, int sw, int dw);
      int e, d, j, srcw, dstw;
      logic b;
      srcw = sw * 16;
      dstw = dw * 16;
      e = 0;
      d = 0;
      j = 0;
      foreach (line_buf[i]) line_buf[i] = '0;
      for (int i = 0; i < srcw; i++) begin
         b = src_bit(row, i, sw);
         e += 2 * dstw;
         if (e <= 0) begin
            if (b) set_line_bit(d);
         end else begin
            while (e > 0) begin
               d = j;
               j++;
               if (b) set_line_bit(d);
               e -= 2 * srcw;
            end
         end
      end
   endfunction

   function automatic void scale_image(int sw, int dw);
      int f, q, nxt, srch, dsth;
      srch = src_h;
      dsth = dst_h;
      f = 0;
      q = 0;
      nxt = 0;
      for (int k = 0; k < srch; k++) begin
         f += 2 * dsth;
         scale_row(k, sw, dw);
         if (f <= 0) begin
            for (int w = 0; w < dw; w++) or_dst(q, w, dw, line_buf[w]);
         end else begin
            while (f > 0) begin
               q = nxt;
               nxt++;
               for (int w = 0; w < dw; w++) or_dst(q, w, dw, line_buf[w]);
               f -= 2 * srch;
            end
         end
      end
   endfunction

   function automatic void keep_image(int sw, int dw);
      int rows, cols, a;
      rows = (src_h < dst_h) ? src_h : dst_h;
      cols = (sw < dw) ? sw : dw;
      for (int r = 0; r < rows; r++)
         for (int w = 0; w < cols; w++) begin
            a = r * sw + w;
            or_dst(r, w, dw, (a < 256) ? src_img[a] : 16'h0000);
         end
   endfunction

   function automatic rsp_type predict_rsp(logic [1:0] op, logic [7:0] idx,
                                           logic [15:0] data);
      rsp_type r;
      r.word = '0;
      r.done = 1'b0;
      case (op)
         OP_LOAD: src_img[idx] = data;
         OP_RUN: begin
            foreach (dst_img[i]) dst_img[i] = '0;
            if (mode == MODE_KEEP) keep_image(src_w >> 4, dst_w >> 4);
            else if (mode == MODE_SCALE) scale_image(src_w >> 4, dst_w >> 4);
            r.done = 1'b1;
         end
         OP_READ: r.word = dst_img[idx];
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int bad;
      bad = 0;
      if (reset) begin
         mode <= MODE_SCALE;
         src_w <= 9'd32;
         src_h <= 9'd32;
         dst_w <= 9'd32;
         dst_h <= 9'd32;
         foreach (dst_img[i]) dst_img[i] = '0;
         pending_rsp.delete();
         mismatches <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MODE:       mode <= csr_write_data[1:0];
               CSR_SRC_WIDTH:  src_w <= csr_write_data;
               CSR_SRC_HEIGHT: src_h <= csr_write_data;
               CSR_DST_WIDTH:  dst_w <= csr_write_data;
               CSR_DST_HEIGHT: dst_h <= csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            pending_rsp.push_back(predict_rsp(req_operation, req_word_index,
                                              req_word_data));
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $error("response transfer with nothing expected");
               bad++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_result_word !== want.word) begin
                  $error("result_word: expected %h, got %h", want.word, rsp_result_word);
                  bad++;
               end
               if (rsp_run_done !== want.done) begin
                  $error("run_done: expected %b, got %b", want.done, rsp_run_done);
                  bad++;
               end
            end
         end
         mismatches <= mismatches + bad;
      end
   end

   // Anything still waiting counts against the run
   assign failures = mismatches + pending_rsp.size();

endmodule

[test/tb_top.sv]
// Testbench top: clock, reset, CSR writes and request/response traffic with
// random idling. Depends on mbr_pkg, mono_bitmap_resize_core and mbr_checker.
module tb_top;
   import mbr_pkg::*;

   localparam logic [1:0] MODE_CLEAR = 2'd2;
   localparam logic [1:0] MODE_ODD   = 2'd3;
   localparam logic [1:0] OP_NONE    = 2'd3;
   localparam int CYCLE_LIMIT = 50000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = '0;
   logic [7:0]  req_word_index = '0;
   logic [15:0] req_word_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_result_word;
   logic        rsp_run_done;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [8:0]  csr_write_data = '0;
   int          failures;
   int          sent = 0;
   int          received = 0;
   int          cycles = 0;
   bit          quiet = 1'b0;
   bit          held = 1'b0;

   mono_bitmap_resize_core DUT (.*);

   mbr_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (rsp_valid && !rsp_stall) received <= received + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Receiver: one long hold-off once traffic is flowing, random bursts otherwise
   initial begin
      forever begin
         @(negedge clock);
         if (!held && received >= 300) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic offer_cmd(logic [1:0] op, logic [7:0] idx, logic [15:0] data);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_word_index <= idx;
      req_word_data <= data;
      do @(posedge clock); while (req_stall);
      sent++;
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (received != sent) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [8:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_geometry(logic [1:0] m, logic [8:0] sw, logic [8:0] sh,
                               logic [8:0] dw, logic [8:0] dh);
      drain();
      write_reg(CSR_MODE, {7'd0, m});
      write_reg(CSR_SRC_WIDTH, sw);
      write_reg(CSR_SRC_HEIGHT, sh);
      write_reg(CSR_DST_WIDTH, dw);
      write_reg(CSR_DST_HEIGHT, dh);
   endtask

   function automatic logic [8:0] pick_width();
      if ($urandom_range(0, 9) == 0) return 9'($urandom_range(0, 511));
      return 9'(16 * $urandom_range(1, 4));
   endfunction

   function automatic logic [8:0] pick_height();
      if ($urandom_range(0, 15) == 0) return 9'($urandom_range(0, 300));
      return 9'($urandom_range(0, 24));
   endfunction

   function automatic logic [1:0] pick_mode();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return MODE_SCALE;
      if (r < 8) return MODE_KEEP;
      if (r < 9) return MODE_CLEAR;
      return MODE_ODD;
   endfunction

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Destination store reads as zero before any run
      offer_cmd(OP_READ, 8'd5, 16'd0);

      // Fill the whole source store so no run ever reads an unwritten word
      for (int i = 0; i < 256; i++)
         offer_cmd(OP_LOAD, 8'(i), 16'($urandom));

      // Directed: reset geometry, then extremes of size and every mode
      offer_cmd(OP_RUN, 8'd0, 16'd0);
      offer_cmd(OP_READ, 8'd0, 16'd0);
      offer_cmd(OP_READ, 8'd255, 16'hffff);
      offer_cmd(OP_NONE, 8'hff, 16'hffff);
      offer_cmd(OP_LOAD, 8'd255, 16'hffff);
      offer_cmd(OP_LOAD, 8'd0, 16'h0000);
      set_geometry(MODE_SCALE, 9'd16, 9'd1, 9'd256, 9'd256);
      offer_cmd(OP_RUN, 8'd0, 16'd0);
      offer_cmd(OP_READ, 8'd255, 16'd0);
      set_geometry(MODE_SCALE, 9'd256, 9'd256, 9'd16, 9'd1);
      offer_cmd(OP_RUN, 8'd0, 16'd0);
      offer_cmd(OP_READ, 8'd0, 16'd0);
      set_geometry(MODE_KEEP, 9'd256, 9'd16, 9'd16, 9'd256);
      offer_cmd(OP_RUN, 8'd0, 16'd0);
      offer_cmd(OP_READ, 8'd17, 16'd0);
      set_geometry(MODE_CLEAR, 9'd32, 9'd8, 9'd32, 9'd8);
      offer_cmd(OP_RUN, 8'd0, 16'd0);
      offer_cmd(OP_READ, 8'd3, 16'd0);
      set_geometry(MODE_ODD, 9'd511, 9'd0, 9'd15, 9'd511);
      offer_cmd(OP_RUN, 8'd0, 16'd0);
      offer_cmd(OP_READ, 8'd1, 16'd0);
      set_geometry(MODE_SCALE, 9'd511, 9'd3, 9'd47, 9'd0);
      offer_cmd(OP_RUN, 8'd0, 16'd0);
      offer_cmd(OP_READ, 8'd0, 16'd0);

      // Random phases: new geometry, some loads and reads around each run
      for (int ph = 0; ph < 16; ph++) begin
         if (ph == 13) quiet = 1'b1;
         set_geometry(pick_mode(), pick_width(), pick_height(), pick_width(),
                      pick_height());
         for (int n = 0; n < 50; n++) begin
            int r;
            r = $urandom_range(0, 99);
            if (n == 20 || n == 35) offer_cmd(OP_RUN, 8'($urandom), 16'($urandom));
            else if (r < 40) offer_cmd(OP_LOAD, 8'($urandom), 16'($urandom));
            else if (r < 95) offer_cmd(OP_READ, 8'($urandom_range(0, 63)),
                                       16'($urandom));
            else offer_cmd(r[0] ? OP_NONE : OP_READ, 8'($urandom), 16'($urandom));
         end
      end

      drain();
      repeat (20) @(negedge clock);
      if (failures == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
